FILE: hdl/abme_pkg.sv
// ----------------------------------------------------------------------------
// abme_pkg
// Shared types, constants and a saturation function for the sample buffer mix engine.
// ----------------------------------------------------------------------------
`default_nettype none
package abme_pkg;
    localparam int unsigned MemoryWordsDefault = 2048;
    localparam int unsigned AddrW = 12;
    localparam int unsigned SampleW = 16;

    typedef enum logic [2:0] {
        ACT_WRITE  = 3'd0,
        ACT_READ   = 3'd1,
        ACT_MIX    = 3'd2,
        ACT_ADD    = 3'd3,
        ACT_HILO   = 3'd4,
        ACT_ILEAVE = 3'd5
    } action_t;

    localparam logic CFG_AUDIO_COUNT = 1'b0;
    localparam logic CFG_AUDIO_OUT_ADDR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_MUL, ST_CALC, ST_WR,
        ST_IL_RD, ST_IL_WR, ST_DONE
    } state_t;

    function automatic logic [SampleW-1:0] sat16(input logic signed [35:0] v);
        logic [SampleW-1:0] r;
        if (v > 36'sd32767) begin
            r = 16'h7fff;
        end else if (v < -36'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/audio_buffer_mix_engine_top.sv
// ----------------------------------------------------------------------------
// audio_buffer_mix_engine_top
// Sample memory with a saturating gain mixer, add mixer, hi-lo gain and
// channel interleave, run word by word by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | ports                      | transfer when
//  input   | s_valid/s_ready, s_*       | s_valid && s_ready
//  result  | m_valid/m_ready, m_*       | m_valid && m_ready
//  config  | cfg_we, cfg_index, cfg_data| cfg_we
// Write and read access memory in ST_RD_B; mix and hi-lo gain step through
// ST_RD_A, ST_RD_B, ST_MUL, ST_CALC and ST_WR per word, add skips ST_MUL;
// interleave reads four words in ST_IL_RD and writes four in ST_IL_WR per
// pair. Unused codes and commands with no whole word or pair go to ST_DONE.
// One item is in work at a time; s_ready is low from acceptance until the
// result transfers. Reset clears control and config registers, not memory.
`default_nettype none
module audio_buffer_mix_engine_top #(
    parameter int unsigned MEMORY_WORDS = abme_pkg::MemoryWordsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [11:0] s_src_addr,
    input  wire logic [11:0] s_src2_addr,
    input  wire logic [11:0] s_dst_addr,
    input  wire logic [11:0] s_count,
    input  wire logic signed [15:0] s_gain,
    input  wire logic signed [3:0]  s_hi_nibble,
    input  wire logic [3:0]  s_lo_nibble,
    input  wire logic signed [15:0] s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_read_data,
    output logic [2:0]       m_finished_action,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_data
);
    localparam int unsigned AW = $clog2(MEMORY_WORDS);

    logic [15:0] mem [MEMORY_WORDS];
    logic [15:0] rdata_reg;

    abme_pkg::state_t state_reg, state_next;
    logic [2:0]  act_reg;
    logic [AW-1:0] src_reg, src2_reg, dst_reg;
    logic [11:0] left_reg;
    logic signed [15:0] gain_reg;
    logic signed [3:0]  hi_reg;
    logic [3:0]  lo_reg;
    logic [15:0] data_reg;
    logic [15:0] a_reg;
    logic signed [35:0] prod_reg;
    logic [1:0]  sub_reg;
    logic [15:0] il_reg [3];
    logic [11:0] cnt_cfg_reg, oaddr_cfg_reg;

    logic [11:0] words_c, pairs_c, il_n;
    logic [AW-1:0] il_o;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_wdata;
    logic signed [16:0] mul_a, mul_b;
    logic signed [20:0] lo_prod_c;
    logic signed [35:0] sum_c;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_cfg_reg <= '0;
            oaddr_cfg_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == abme_pkg::CFG_AUDIO_COUNT) begin
                cnt_cfg_reg <= cfg_data;
            end else begin
                oaddr_cfg_reg <= cfg_data;
            end
        end
    end

    assign words_c = 12'((13'(s_count) + 13'd1) >> 1);
    assign il_n = (s_count == '0) ? cnt_cfg_reg : s_count;
    assign pairs_c = il_n >> 2;
    assign il_o = (s_count == '0) ? AW'(oaddr_cfg_reg[11:1]) : AW'(s_dst_addr[11:1]);

    // shared multiplier
    always_comb begin
        if (act_reg == abme_pkg::ACT_MIX) begin
            mul_a = 17'(signed'(a_reg));
            mul_b = 17'(gain_reg);
        end else begin
            mul_a = 17'(signed'(rdata_reg));
            mul_b = 17'(signed'({hi_reg, 12'd0}));
        end
    end

    assign lo_prod_c = 21'(signed'(a_reg)) * 21'(signed'({1'b0, lo_reg}));

    always_comb begin
        case (act_reg)
            abme_pkg::ACT_MIX:  sum_c = (prod_reg >>> 15) + 36'(signed'(rdata_reg));
            abme_pkg::ACT_ADD:  sum_c = 36'(signed'(a_reg)) + 36'(signed'(rdata_reg));
            default: sum_c = (prod_reg >>> 16) + 36'(lo_prod_c);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            abme_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_action)
                        abme_pkg::ACT_WRITE, abme_pkg::ACT_READ: state_next = abme_pkg::ST_RD_B;
                        abme_pkg::ACT_MIX, abme_pkg::ACT_ADD, abme_pkg::ACT_HILO:
                            state_next = (words_c == '0) ? abme_pkg::ST_DONE : abme_pkg::ST_RD_A;
                        abme_pkg::ACT_ILEAVE:
                            state_next = (pairs_c == '0) ? abme_pkg::ST_DONE : abme_pkg::ST_IL_RD;
                        default: state_next = abme_pkg::ST_DONE;
                    endcase
                end
            end
            abme_pkg::ST_RD_A: state_next = abme_pkg::ST_RD_B;
            abme_pkg::ST_RD_B: begin
                if (act_reg == abme_pkg::ACT_WRITE || act_reg == abme_pkg::ACT_READ) begin
                    state_next = abme_pkg::ST_DONE;
                end else if (act_reg == abme_pkg::ACT_ADD) begin
                    state_next = abme_pkg::ST_CALC;
                end else begin
                    state_next = abme_pkg::ST_MUL;
                end
            end
            abme_pkg::ST_MUL:  state_next = abme_pkg::ST_CALC;
            abme_pkg::ST_CALC: state_next = abme_pkg::ST_WR;
            abme_pkg::ST_WR:
                state_next = (left_reg == 12'd1) ? abme_pkg::ST_DONE : abme_pkg::ST_RD_A;
            abme_pkg::ST_IL_RD:
                if (sub_reg == 2'd3) begin
                    state_next = abme_pkg::ST_IL_WR;
                end
            abme_pkg::ST_IL_WR:
                if (sub_reg == 2'd3) begin
                    state_next = (left_reg == 12'd1) ? abme_pkg::ST_DONE : abme_pkg::ST_IL_RD;
                end
            abme_pkg::ST_DONE:
                if (m_ready) begin
                    state_next = abme_pkg::ST_IDLE;
                end
            default: state_next = abme_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == abme_pkg::ST_IDLE);
        m_valid = (state_reg == abme_pkg::ST_DONE);
        m_read_data = (act_reg == abme_pkg::ACT_READ) ? rdata_reg : '0;
        m_finished_action = act_reg;
        mem_we = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = 16'(sum_c[15:0]);
        mem_raddr = dst_reg;
        case (state_reg)
            abme_pkg::ST_RD_A: begin
                mem_raddr = (act_reg == abme_pkg::ACT_HILO) ? dst_reg : src_reg;
            end
            abme_pkg::ST_RD_B: begin
                mem_we = (act_reg == abme_pkg::ACT_WRITE);
                mem_wdata = data_reg;
            end
            abme_pkg::ST_WR: begin
                mem_we = 1'b1;
                mem_wdata = abme_pkg::sat16(sum_c);
            end
            abme_pkg::ST_IL_RD: begin
                mem_raddr = (sub_reg[1] ? src2_reg : src_reg) + AW'(sub_reg[0]);
            end
            abme_pkg::ST_IL_WR: begin
                mem_we = 1'b1;
                mem_waddr = dst_reg + AW'(sub_reg);
                case (sub_reg)
                    2'd0: mem_wdata = rdata_reg;
                    2'd1: mem_wdata = il_reg[1];
                    2'd2: mem_wdata = il_reg[2];
                    default: mem_wdata = il_reg[0];
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abme_pkg::ST_IDLE;
            act_reg <= '0;
            left_reg <= '0;
            sub_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                abme_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        act_reg <= s_action;
                        src_reg <= AW'(s_src_addr[11:1]);
                        src2_reg <= AW'(s_src2_addr[11:1]);
                        gain_reg <= s_gain;
                        hi_reg <= s_hi_nibble;
                        lo_reg <= s_lo_nibble;
                        data_reg <= s_data;
                        sub_reg <= '0;
                        if (s_action == abme_pkg::ACT_ILEAVE) begin
                            dst_reg <= il_o;
                            left_reg <= pairs_c;
                        end else begin
                            dst_reg <= AW'(s_dst_addr[11:1]);
                            left_reg <= words_c;
                        end
                    end
                end
                abme_pkg::ST_RD_B: begin
                    a_reg <= rdata_reg;
                end
                abme_pkg::ST_MUL: begin
                    prod_reg <= 36'(mul_a * mul_b);
                    if (act_reg == abme_pkg::ACT_HILO) begin
                        a_reg <= rdata_reg;
                    end
                end
                abme_pkg::ST_WR: begin
                    left_reg <= left_reg - 12'd1;
                    src_reg <= src_reg + AW'(1);
                    dst_reg <= dst_reg + AW'(1);
                end
                abme_pkg::ST_IL_RD: begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg != 2'd0) begin
                        il_reg[sub_reg - 2'd1] <= rdata_reg;
                    end
                end
                abme_pkg::ST_IL_WR: begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd3) begin
                        left_reg <= left_reg - 12'd1;
                        src_reg <= src_reg + AW'(2);
                        src2_reg <= src2_reg + AW'(2);
                        dst_reg <= dst_reg + AW'(4);
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives audio_buffer_mix_engine_top with directed and random sample
// commands under changing handshake pressure, predicts every result and the
// sample memory contents, and compares each result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    localparam int unsigned Words = 2048;
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]         act;
        logic [11:0]        src;
        logic [11:0]        src2;
        logic [11:0]        dst;
        logic [11:0]        cnt;
        logic signed [15:0] gain;
        logic signed [3:0]  hi;
        logic [3:0]         lo;
        logic signed [15:0] data;
    } sample_cmd_t;

    typedef struct {
        logic [15:0] rdata;
        logic [2:0]  act;
    } mix_result_t;

    class mix_engine_model;
        logic signed [15:0] mem [Words];
        bit                 written [Words];
        logic [11:0]        cfg_count;
        logic [11:0]        cfg_out;
        mix_result_t        pending [$];
        int                 mismatches;
        int                 results;
        int                 per_action [8];

        function int unsigned word_of(logic [11:0] a, int unsigned i);
            return ((a >> 1) + i) % Words;
        endfunction

        function logic signed [15:0] clip(int v);
            if (v > 32767) begin
                return 16'sh7fff;
            end
            if (v < -32768) begin
                return 16'sh8000;
            end
            return v[15:0];
        endfunction

        function void note_transfer(sample_cmd_t c);
            mix_result_t r;
            int unsigned n, d, p, nwords;
            logic [11:0] o;
            int t, v;
            logic signed [15:0] l0, l1, r0, r1;
            r.rdata = '0;
            r.act = c.act;
            nwords = (int'(c.cnt) + 1) >> 1;
            per_action[c.act]++;
            case (c.act)
                abme_pkg::ACT_WRITE: begin
                    mem[word_of(c.dst, 0)] = c.data;
                    written[word_of(c.dst, 0)] = 1;
                end
                abme_pkg::ACT_READ: r.rdata = mem[word_of(c.dst, 0)];
                abme_pkg::ACT_MIX: begin
                    for (int unsigned i = 0; i < nwords; i++) begin
                        d = word_of(c.dst, i);
                        t = ((int'(mem[word_of(c.src, i)]) * int'(c.gain)) >>> 15)
                            + int'(mem[d]);
                        mem[d] = clip(t);
                    end
                end
                abme_pkg::ACT_ADD: begin
                    for (int unsigned i = 0; i < nwords; i++) begin
                        d = word_of(c.dst, i);
                        mem[d] = clip(int'(mem[word_of(c.src, i)]) + int'(mem[d]));
                    end
                end
                abme_pkg::ACT_HILO: begin
                    for (int unsigned i = 0; i < nwords; i++) begin
                        d = word_of(c.dst, i);
                        v = int'(mem[d]);
                        mem[d] = clip(((v * (int'(c.hi) * 4096)) >>> 16)
                                      + v * int'(c.lo));
                    end
                end
                abme_pkg::ACT_ILEAVE: begin
                    n = 32'(c.cnt);
                    o = c.dst;
                    if (n == 0) begin
                        n = 32'(cfg_count);
                        o = cfg_out;
                    end
                    for (p = 0; p < n / 4; p++) begin
                        l0 = mem[word_of(c.src, 2 * p)];
                        l1 = mem[word_of(c.src, 2 * p + 1)];
                        r0 = mem[word_of(c.src2, 2 * p)];
                        r1 = mem[word_of(c.src2, 2 * p + 1)];
                        mem[word_of(o, 4 * p)] = r1;
                        mem[word_of(o, 4 * p + 1)] = l1;
                        mem[word_of(o, 4 * p + 2)] = r0;
                        mem[word_of(o, 4 * p + 3)] = l0;
                        for (int k = 0; k < 4; k++) begin
                            written[word_of(o, 4 * p + k)] = 1;
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] rdata, logic [2:0] act);
            mix_result_t e;
            results++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result with no command pending (data %h act %0d)",
                             rdata, act);
                end
                return;
            end
            e = pending.pop_front();
            if (rdata !== e.rdata || act !== e.act) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: read_data exp %h got %h, action exp %0d got %0d",
                             e.rdata, rdata, e.act, act);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_action;
    logic [11:0] s_src_addr;
    logic [11:0] s_src2_addr;
    logic [11:0] s_dst_addr;
    logic [11:0] s_count;
    logic signed [15:0] s_gain;
    logic signed [3:0]  s_hi_nibble;
    logic [3:0]  s_lo_nibble;
    logic signed [15:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic signed [15:0] m_read_data;
    logic [2:0]  m_finished_action;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_data;

    mix_engine_model model = new();
    int          send_idle;
    int          recv_idle;
    bit          hold_req;
    int          hold_left;
    int          sent;

    audio_buffer_mix_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_src_addr(s_src_addr), .s_src2_addr(s_src2_addr),
        .s_dst_addr(s_dst_addr), .s_count(s_count), .s_gain(s_gain),
        .s_hi_nibble(s_hi_nibble), .s_lo_nibble(s_lo_nibble), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data),
        .m_finished_action(m_finished_action),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("FAIL audio_buffer_mix_engine_top");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            model.check_result(m_read_data, m_finished_action);
        end
    end

    initial begin
        m_ready = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_cmd(sample_cmd_t c);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid = 1;
        s_action = c.act;
        s_src_addr = c.src;
        s_src2_addr = c.src2;
        s_dst_addr = c.dst;
        s_count = c.cnt;
        s_gain = c.gain;
        s_hi_nibble = c.hi;
        s_lo_nibble = c.lo;
        s_data = c.data;
        forever begin
            @(posedge aclk);
            if (s_ready) begin
                break;
            end
        end
        model.note_transfer(c);
        sent++;
    endtask

    task automatic fill_word(int unsigned w);
        sample_cmd_t c;
        if (!model.written[w]) begin
            c.act = abme_pkg::ACT_WRITE;
            c.src = 12'($urandom);
            c.src2 = 12'($urandom);
            c.dst = 12'((w << 1) | $urandom_range(1));
            c.cnt = 12'($urandom);
            c.gain = 16'($urandom);
            c.hi = 4'($urandom);
            c.lo = 4'($urandom);
            c.data = 16'($urandom);
            send_cmd(c);
        end
    endtask

    // Write every word a command will read before issuing it.
    task automatic issue(sample_cmd_t c);
        int unsigned nwords, n;
        nwords = (int'(c.cnt) + 1) >> 1;
        case (c.act)
            abme_pkg::ACT_READ: fill_word(model.word_of(c.dst, 0));
            abme_pkg::ACT_MIX, abme_pkg::ACT_ADD: begin
                for (int unsigned i = 0; i < nwords; i++) begin
                    fill_word(model.word_of(c.src, i));
                    fill_word(model.word_of(c.dst, i));
                end
            end
            abme_pkg::ACT_HILO: begin
                for (int unsigned i = 0; i < nwords; i++) begin
                    fill_word(model.word_of(c.dst, i));
                end
            end
            abme_pkg::ACT_ILEAVE: begin
                n = (c.cnt == '0) ? 32'(model.cfg_count) : 32'(c.cnt);
                for (int unsigned i = 0; i < (n / 4) * 2; i++) begin
                    fill_word(model.word_of(c.src, i));
                    fill_word(model.word_of(c.src2, i));
                end
            end
            default: ;
        endcase
        send_cmd(c);
    endtask

    task automatic directed(logic [2:0] act, logic [11:0] src, logic [11:0] src2,
                            logic [11:0] dst, logic [11:0] cnt, logic [15:0] gain,
                            logic [3:0] hi, logic [3:0] lo, logic [15:0] data);
        sample_cmd_t c;
        c.act = act;
        c.src = src;
        c.src2 = src2;
        c.dst = dst;
        c.cnt = cnt;
        c.gain = gain;
        c.hi = hi;
        c.lo = lo;
        c.data = data;
        issue(c);
    endtask

    // Random addresses stay in a low window so the fill writes stay few.
    task automatic random_cmd();
        sample_cmd_t c;
        int unsigned k;
        k = $urandom_range(99);
        if (k < 3) begin
            c.act = ($urandom_range(1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
        end else begin
            c.act = 3'($urandom_range(5));
        end
        c.src = 12'($urandom_range(255));
        c.src2 = 12'($urandom_range(255));
        c.dst = 12'($urandom_range(255));
        k = $urandom_range(99);
        if (k < 80) begin
            c.cnt = 12'($urandom_range(40));
        end else begin
            c.cnt = 12'($urandom_range(200));
        end
        c.gain = 16'($urandom);
        c.hi = 4'($urandom);
        c.lo = 4'($urandom);
        c.data = 16'($urandom);
        issue(c);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 0;
        while (model.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] v);
        @(negedge aclk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge aclk);
        cfg_we = 0;
        if (idx == abme_pkg::CFG_AUDIO_COUNT) begin
            model.cfg_count = v;
        end else begin
            model.cfg_out = v;
        end
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_action = abme_pkg::ACT_WRITE;
        s_src_addr = '0;
        s_src2_addr = '0;
        s_dst_addr = '0;
        s_count = '0;
        s_gain = '0;
        s_hi_nibble = '0;
        s_lo_nibble = '0;
        s_data = '0;
        cfg_we = 0;
        cfg_index = abme_pkg::CFG_AUDIO_COUNT;
        cfg_data = '0;
        hold_req = 0;
        sent = 0;
        send_idle = 0;
        recv_idle = 0;
        model.cfg_count = '0;
        model.cfg_out = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        write_reg(abme_pkg::CFG_AUDIO_COUNT, 12'd16);
        write_reg(abme_pkg::CFG_AUDIO_OUT_ADDR, 12'hfff);
        directed(abme_pkg::ACT_WRITE, '0, '0, 12'h000, '0, '0, '0, '0, 16'h7fff);
        directed(abme_pkg::ACT_WRITE, '0, '0, 12'hfff, '0, '0, '0, '0, 16'h8000);
        directed(abme_pkg::ACT_READ, '0, '0, 12'h001, '0, '0, '0, '0, '0);
        directed(abme_pkg::ACT_READ, '0, '0, 12'hffe, '0, '0, '0, '0, '0);
        directed(abme_pkg::ACT_MIX, 12'hff0, '0, 12'h010, 12'd20, 16'h8000, '0, '0, '0);
        directed(abme_pkg::ACT_MIX, 12'h001, '0, 12'hffd, 12'd7, 16'h7fff, '0, '0, '0);
        directed(abme_pkg::ACT_MIX, 12'h100, '0, 12'h200, 12'd0, 16'h4000, '0, '0, '0);
        directed(abme_pkg::ACT_ADD, 12'h000, '0, 12'h000, 12'd3, '0, '0, '0, '0);
        directed(abme_pkg::ACT_ADD, 12'hffe, '0, 12'h002, 12'd61, '0, '0, '0, '0);
        directed(abme_pkg::ACT_HILO, '0, '0, 12'hff8, 12'd16, '0, 4'h8, 4'hf, '0);
        directed(abme_pkg::ACT_HILO, '0, '0, 12'h020, 12'd9, '0, 4'h7, 4'h0, '0);
        directed(abme_pkg::ACT_HILO, '0, '0, 12'h020, 12'd0, '0, 4'h1, 4'h3, '0);
        directed(abme_pkg::ACT_ILEAVE, 12'h040, 12'hffc, 12'h300, 12'd0, '0, '0, '0, '0);
        directed(abme_pkg::ACT_ILEAVE, 12'h041, 12'h081, 12'h401, 12'd11, '0, '0, '0, '0);
        directed(ACT_SPARE_LO, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 16'hffff, 4'hf, 4'hf,
                 16'hffff);
        directed(ACT_SPARE_HI, '0, '0, '0, '0, '0, '0, '0, '0);
        directed(abme_pkg::ACT_READ, '0, '0, 12'h300, '0, '0, '0, '0, '0);
        directed(abme_pkg::ACT_READ, '0, '0, 12'hffe, '0, '0, '0, '0, '0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_reg(abme_pkg::CFG_AUDIO_COUNT, 12'd0);
                    write_reg(abme_pkg::CFG_AUDIO_OUT_ADDR, 12'd0);
                    send_idle = 38;
                    recv_idle = 63;
                end
                1: begin
                    write_reg(abme_pkg::CFG_AUDIO_COUNT, 12'd203);
                    write_reg(abme_pkg::CFG_AUDIO_OUT_ADDR, 12'd2);
                    send_idle = 63;
                    recv_idle = 38;
                end
                default: begin
                    write_reg(abme_pkg::CFG_AUDIO_COUNT, 12'($urandom_range(200)));
                    write_reg(abme_pkg::CFG_AUDIO_OUT_ADDR, 12'($urandom));
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int n = 0; n < 285; n++) begin
                if (ph == 1 && n == 100) begin
                    hold_req = 1;
                end
                random_cmd();
            end
            drain();
        end

        while (hold_left > 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (model.pending.size() != 0) begin
            model.mismatches += model.pending.size();
            $display("ERROR: %0d results never arrived", model.pending.size());
        end
        $display("Run covered %0d commands and %0d results, %0d mismatches.",
                 sent, model.results, model.mismatches);
        $display("Per action: wr %0d rd %0d mix %0d add %0d hilo %0d ilv %0d unused %0d",
                 model.per_action[0], model.per_action[1], model.per_action[2],
                 model.per_action[3], model.per_action[4], model.per_action[5],
                 model.per_action[6] + model.per_action[7]);
        if (model.mismatches == 0) begin
            $display("PASS audio_buffer_mix_engine_top");
        end else begin
            $display("FAIL audio_buffer_mix_engine_top");
        end
        $finish;
    end
endmodule
`default_nettype wire
